FILE: sv/fisn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisn_pkg
// Shared constants and helpers for the fast inverse square root normalizer.
// ----------------------------------------------------------------------------
package fisn_pkg;

  localparam logic [31:0] MAGIC_WORD   = 32'h5f3759df;
  localparam logic [31:0] ONE_HALF     = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] DEFAULT_NAN  = 32'hffc00000;
  localparam logic [31:0] QUIET_BIT    = 32'h00400000;
  localparam logic [30:0] INF_MAG      = 31'h7f800000;

  // Latency of each floating-point unit and of the whole pipeline.
  localparam int unsigned OpLat   = 2;
  localparam int unsigned PipeLat = 9 * OpLat;

  // Count of leading zeros of a 48-bit word, 48 for an all-zero word.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] c;
    c = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        c = 6'(47 - i);
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/fisn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisn_in_if / fisn_out_if
// Valid/ready channels that carry an input vector and a result vector.
// ----------------------------------------------------------------------------
interface fisn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vec_x;
  logic [31:0] vec_y;
  logic [31:0] vec_z;
  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface fisn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface
`default_nettype wire

FILE: sv/fisn_fmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisn_fmul
// Two-stage single-precision multiplier, round to nearest even.
// ----------------------------------------------------------------------------
module fisn_fmul
  import fisn_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] p_o
);

  logic [7:0]        ea, eb;
  logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0]       ma, mb, mna, mnb;
  logic [5:0]        lza, lzb;
  logic signed [9:0] expa, expb;
  logic              sign_d, sign_q, spec_d, spec_q;
  logic [31:0]       spec_word_d, spec_word_q;
  logic signed [10:0] exp_d, exp_q;
  logic [47:0]       prod_d, prod_q;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    nan_a  = (ea == 8'hff) && (a_i[22:0] != '0);
    nan_b  = (eb == 8'hff) && (b_i[22:0] != '0);
    inf_a  = (ea == 8'hff) && (a_i[22:0] == '0);
    inf_b  = (eb == 8'hff) && (b_i[22:0] == '0);
    zero_a = (a_i[30:0] == '0);
    zero_b = (b_i[30:0] == '0);
    ma     = {ea != 8'd0, a_i[22:0]};
    mb     = {eb != 8'd0, b_i[22:0]};
    lza    = lzc48({ma, 24'd0});
    lzb    = lzc48({mb, 24'd0});
    mna    = ma << lza[4:0];
    mnb    = mb << lzb[4:0];
    expa   = $signed({2'b00, (ea == 8'd0) ? 8'd1 : ea}) - $signed({4'b0000, lza});
    expb   = $signed({2'b00, (eb == 8'd0) ? 8'd1 : eb}) - $signed({4'b0000, lzb});
    exp_d  = $signed({expa[9], expa}) + $signed({expb[9], expb}) - 11'sd127;
    prod_d = mna * mnb;
    sign_d = a_i[31] ^ b_i[31];
    spec_d = 1'b1;
    if (nan_a) begin
      spec_word_d = a_i | QUIET_BIT;
    end else if (nan_b) begin
      spec_word_d = b_i | QUIET_BIT;
    end else if ((inf_a && zero_b) || (inf_b && zero_a)) begin
      spec_word_d = DEFAULT_NAN;
    end else if (inf_a || inf_b) begin
      spec_word_d = {sign_d, INF_MAG};
    end else if (zero_a || zero_b) begin
      spec_word_d = {sign_d, 31'd0};
    end else begin
      spec_word_d = '0;
      spec_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_q      <= sign_d;
      spec_q      <= spec_d;
      spec_word_q <= spec_word_d;
      exp_q       <= exp_d;
      prod_q      <= prod_d;
    end
  end

  logic               carry;
  logic [47:0]        nrm;
  logic signed [10:0] e, neg;
  logic [5:0]         sh;
  logic [9:0]         eeff;
  logic [10:0]        em1;
  logic [95:0]        wide;
  logic [23:0]        m;
  logic               g, st;
  logic [24:0]        m_r;
  logic [33:0]        tot;
  logic [31:0]        res_d, res_q;

  always_comb begin
    carry = prod_q[47];
    nrm   = carry ? prod_q : {prod_q[46:0], 1'b0};
    e     = exp_q + $signed({10'd0, carry});
    neg   = 11'sd1 - e;
    if (e > 11'sd0) begin
      eeff = e[9:0];
      sh   = 6'd0;
    end else begin
      eeff = 10'd1;
      sh   = (neg > 11'sd63) ? 6'd63 : neg[5:0];
    end
    wide  = {nrm, 48'd0} >> sh;
    m     = wide[95:72];
    g     = wide[71];
    st    = |wide[70:0];
    m_r   = {1'b0, m} + {24'd0, g & (st | m[0])};
    em1   = {1'b0, eeff} - 11'd1;
    tot   = {em1, 23'd0} + {9'd0, m_r};
    if (spec_q) begin
      res_d = spec_word_q;
    end else if (tot >= {3'd0, INF_MAG}) begin
      res_d = {sign_q, INF_MAG};
    end else begin
      res_d = {sign_q, tot[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign p_o = res_q;

endmodule
`default_nettype wire

FILE: sv/fisn_fadd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisn_fadd
// Two-stage single-precision adder and subtractor, round to nearest even.
// ----------------------------------------------------------------------------
module fisn_fadd
  import fisn_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic        sub_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] s_o
);

  logic        sbe, nan_a, nan_b, inf_a, inf_b, swap, eff_sub;
  logic [31:0] bb, big, sml;
  logic [7:0]  exb, exs, d;
  logic [5:0]  sh;
  logic [26:0] mbig, msml, al;
  logic [58:0] wide;
  logic        sign_d, sign_q, zsign_d, zsign_q, spec_d, spec_q;
  logic [31:0] spec_word_d, spec_word_q;
  logic [7:0]  exp_d, exp_q;
  logic [27:0] sum_d, sum_q;

  always_comb begin
    sbe   = b_i[31] ^ sub_i;
    bb    = {sbe, b_i[30:0]};
    nan_a = (a_i[30:23] == 8'hff) && (a_i[22:0] != '0);
    nan_b = (b_i[30:23] == 8'hff) && (b_i[22:0] != '0);
    inf_a = (a_i[30:0] == INF_MAG);
    inf_b = (b_i[30:0] == INF_MAG);
    swap  = a_i[30:0] < b_i[30:0];
    big   = swap ? bb : a_i;
    sml   = swap ? a_i : bb;
    exb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    exs   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = exb - exs;
    sh    = (d > 8'd31) ? 6'd31 : d[5:0];
    mbig  = {big[30:23] != 8'd0, big[22:0], 3'd0};
    msml  = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
    wide  = {msml, 32'd0} >> sh;
    al    = {wide[58:33], wide[32] | (|wide[31:0])};
    eff_sub = a_i[31] ^ sbe;
    sum_d = eff_sub ? ({1'b0, mbig} - {1'b0, al}) : ({1'b0, mbig} + {1'b0, al});
    exp_d   = exb;
    sign_d  = big[31];
    zsign_d = a_i[31] & sbe;
    spec_d  = 1'b1;
    if (nan_a) begin
      spec_word_d = a_i | QUIET_BIT;
    end else if (nan_b) begin
      spec_word_d = b_i | QUIET_BIT;
    end else if (inf_a && inf_b && eff_sub) begin
      spec_word_d = DEFAULT_NAN;
    end else if (inf_a) begin
      spec_word_d = a_i;
    end else if (inf_b) begin
      spec_word_d = bb;
    end else begin
      spec_word_d = '0;
      spec_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_q      <= sign_d;
      zsign_q     <= zsign_d;
      spec_q      <= spec_d;
      spec_word_q <= spec_word_d;
      exp_q       <= exp_d;
      sum_q       <= sum_d;
    end
  end

  logic [26:0] nrm;
  logic [8:0]  e;
  logic [5:0]  lz;
  logic [7:0]  lsh, lim;
  logic [23:0] m;
  logic        g, st;
  logic [24:0] m_r;
  logic [8:0]  em1;
  logic [33:0] tot;
  logic [31:0] res_d, res_q;

  always_comb begin
    lz  = lzc48({sum_q[26:0], 21'd0});
    lim = exp_q - 8'd1;
    lsh = ({2'b00, lz} < lim) ? {2'b00, lz} : lim;
    if (sum_q[27]) begin
      nrm = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e   = {1'b0, exp_q} + 9'd1;
    end else begin
      nrm = sum_q[26:0] << lsh[4:0];
      e   = {1'b0, exp_q} - {1'b0, lsh};
    end
    m   = nrm[26:3];
    g   = nrm[2];
    st  = |nrm[1:0];
    m_r = {1'b0, m} + {24'd0, g & (st | m[0])};
    em1 = e - 9'd1;
    tot = {2'd0, em1, 23'd0} + {9'd0, m_r};
    if (spec_q) begin
      res_d = spec_word_q;
    end else if (sum_q == '0) begin
      res_d = {zsign_q, 31'd0};
    end else if (tot >= {3'd0, INF_MAG}) begin
      res_d = {sign_q, INF_MAG};
    end else begin
      res_d = {sign_q, tot[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign s_o = res_q;

endmodule
`default_nettype wire

FILE: sv/fast_inverse_sqrt_normalize_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_normalize_unit
// Scales a single-precision 3-vector to unit length with the magic-constant
// inverse square root estimate and one Newton step.
//
// A vector is taken from in_i and its scaled components appear on out_o.
// Both channels transfer on a clock edge with valid and ready high.
// The path is nine float operations (three multiplies, two adds,
// three multiplies, a subtract, one multiply, three final multiplies, with
// parallel ones sharing a slot), each two register stages deep.
// Throughput is one vector per cycle. When the squared length is zero the
// input components are passed through unchanged.
// All stages advance together; when the receiver stalls a valid result,
// the whole pipeline holds and in_i.ready drops, so nothing is lost.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_normalize_unit
  import fisn_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fisn_in_if.sink     in_i,
  fisn_out_if.source  out_o
);

  localparam int unsigned GLen = 4 * OpLat;
  localparam int unsigned ZLen = 6 * OpLat;

  logic              adv;
  logic [PipeLat-1:0] vld_q;
  logic [95:0]       xyz_q [PipeLat];
  logic [31:0]       sqz_q [OpLat];
  logic [31:0]       g_q   [GLen];
  logic              zero_q [ZLen];

  logic [31:0] sqx, sqy, sqz, s1, s, guess, x2, t1, t2, t3, inv, rx, ry, rz;
  logic [95:0] xin, xmid, xout;

  assign adv        = !vld_q[PipeLat-1] || out_o.ready;
  assign in_i.ready = adv;
  assign xin        = {in_i.vec_x, in_i.vec_y, in_i.vec_z};
  assign xmid       = xyz_q[PipeLat-OpLat-1];
  assign xout       = xyz_q[PipeLat-1];
  assign guess      = MAGIC_WORD - {s[31], s[31:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeLat-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xyz_q[0]  <= xin;
      sqz_q[0]  <= sqz;
      g_q[0]    <= guess;
      zero_q[0] <= (s[30:0] == '0);
      for (int i = 1; i < PipeLat; i++) xyz_q[i] <= xyz_q[i-1];
      for (int i = 1; i < OpLat; i++) sqz_q[i] <= sqz_q[i-1];
      for (int i = 1; i < GLen; i++) g_q[i] <= g_q[i-1];
      for (int i = 1; i < ZLen; i++) zero_q[i] <= zero_q[i-1];
    end
  end

  fisn_fmul u_sqx (.clk_i, .en_i(adv), .a_i(in_i.vec_x), .b_i(in_i.vec_x), .p_o(sqx));
  fisn_fmul u_sqy (.clk_i, .en_i(adv), .a_i(in_i.vec_y), .b_i(in_i.vec_y), .p_o(sqy));
  fisn_fmul u_sqz (.clk_i, .en_i(adv), .a_i(in_i.vec_z), .b_i(in_i.vec_z), .p_o(sqz));
  fisn_fadd u_s1  (.clk_i, .en_i(adv), .sub_i(1'b0), .a_i(sqx), .b_i(sqy), .s_o(s1));
  fisn_fadd u_s   (.clk_i, .en_i(adv), .sub_i(1'b0), .a_i(s1), .b_i(sqz_q[OpLat-1]),
                   .s_o(s));
  fisn_fmul u_x2  (.clk_i, .en_i(adv), .a_i(s), .b_i(ONE_HALF), .p_o(x2));
  fisn_fmul u_t1  (.clk_i, .en_i(adv), .a_i(x2), .b_i(g_q[OpLat-1]), .p_o(t1));
  fisn_fmul u_t2  (.clk_i, .en_i(adv), .a_i(t1), .b_i(g_q[2*OpLat-1]), .p_o(t2));
  fisn_fadd u_t3  (.clk_i, .en_i(adv), .sub_i(1'b1), .a_i(THREE_HALVES), .b_i(t2),
                   .s_o(t3));
  fisn_fmul u_inv (.clk_i, .en_i(adv), .a_i(g_q[GLen-1]), .b_i(t3), .p_o(inv));
  fisn_fmul u_rx  (.clk_i, .en_i(adv), .a_i(xmid[95:64]), .b_i(inv), .p_o(rx));
  fisn_fmul u_ry  (.clk_i, .en_i(adv), .a_i(xmid[63:32]), .b_i(inv), .p_o(ry));
  fisn_fmul u_rz  (.clk_i, .en_i(adv), .a_i(xmid[31:0]), .b_i(inv), .p_o(rz));

  assign out_o.valid = vld_q[PipeLat-1];
  assign out_o.out_x = zero_q[ZLen-1] ? xout[95:64] : rx;
  assign out_o.out_y = zero_q[ZLen-1] ? xout[63:32] : ry;
  assign out_o.out_z = zero_q[ZLen-1] ? xout[31:0]  : rz;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_i.valid) |=> !vld_q[0])
    else $error("bubble did not enter the pipeline");

  a_zero_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && zero_q[ZLen-1]) |-> (out_o.out_x == xout[95:64]))
    else $error("zero-length vector not passed through");

endmodule
`default_nettype wire
